@@ rtl/gsc_pkg.sv @@
package gsc_pkg;

	localparam logic [19:0] WL_MAX     = 20'hFFFFF;
	localparam logic [19:0] WL_RESET   = 20'd140800;
	localparam logic [31:0] MASS_RESET = 32'd65536;

	// result status codes
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_SAT = 2'd1;
	localparam logic [1:0] STAT_HOR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MASS    = 2'd0;
	localparam logic [1:0] REG_INIT_WL = 2'd1;

	// color channels
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// iteration counts of the shared unit
	localparam logic [5:0] MUL_LAST      = 6'd31;
	localparam logic [5:0] DIV_MAIN_LAST = 6'd39;
	localparam logic [5:0] DIV_RAMP_LAST = 6'd31;
	localparam logic [5:0] SQRT_LAST     = 6'd19;

	typedef struct packed {
		logic        restart;
		logic [31:0] radius_before;
		logic [31:0] radius_after;
	} item_t;

	typedef struct packed {
		logic [31:0] mass;
		logic [19:0] init_wl;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [19:0] wavelength;
		logic [1:0]  status;
	} result_t;

	// one channel of the color ramp: a constant, or (c0*span + c1*d) / (100*span)
	typedef struct packed {
		logic               is_ramp;
		logic [7:0]         cval;
		logic [6:0]         c0;
		logic signed [7:0]  c1;
		logic [14:0]        d;
		logic [14:0]        span;
	} ramp_t;

	function automatic ramp_t mk_ramp(logic [6:0] c0, logic signed [7:0] c1,
			logic [19:0] d, logic [14:0] span);
		ramp_t r;
		r.is_ramp = 1'b1;
		r.cval    = 8'd0;
		r.c0      = c0;
		r.c1      = c1;
		r.d       = d[14:0];
		r.span    = span;
		return r;
	endfunction

	function automatic ramp_t mk_const(logic [7:0] v);
		ramp_t r;
		r      = '0;
		r.cval = v;
		return r;
	endfunction

	// first matching range wins; outside 380..780 nm is black
	function automatic ramp_t ramp_info(logic [19:0] w, logic [1:0] ch);
		ramp_t r;
		r = mk_const(8'd0);
		if (w < 20'd97280 || w > 20'd199680) begin
			r = mk_const(8'd0);
		end else if (w <= 20'd104960) begin
			if (ch == CH_RED) r = mk_ramp(7'd60, -8'sd41, 20'd104960 - w, 15'd7680);
			else if (ch == CH_BLUE) r = mk_ramp(7'd39, 8'sd60, 20'd104960 - w, 15'd7680);
		end else if (w <= 20'd112640) begin
			if (ch == CH_RED) r = mk_ramp(7'd19, -8'sd19, 20'd112640 - w, 15'd7680);
			else if (ch == CH_BLUE) r = mk_const(8'd255);
		end else if (w <= 20'd125440) begin
			if (ch == CH_GREEN) r = mk_ramp(7'd100, -8'sd100, 20'd125440 - w, 15'd12800);
			else if (ch == CH_BLUE) r = mk_const(8'd255);
		end else if (w <= 20'd130560) begin
			if (ch == CH_GREEN) r = mk_const(8'd255);
			else if (ch == CH_BLUE) r = mk_ramp(7'd0, 8'sd100, 20'd130560 - w, 15'd5120);
		end else if (w <= 20'd148480) begin
			if (ch == CH_RED) r = mk_ramp(7'd100, -8'sd100, 20'd148480 - w, 15'd17920);
			else if (ch == CH_GREEN) r = mk_const(8'd255);
		end else if (w <= 20'd163840) begin
			if (ch == CH_RED) r = mk_const(8'd255);
			else if (ch == CH_GREEN) r = mk_ramp(7'd0, 8'sd100, 20'd163840 - w, 15'd15360);
		end else if (w <= 20'd179200) begin
			if (ch == CH_RED) r = mk_const(8'd255);
		end else begin
			if (ch == CH_RED) r = mk_ramp(7'd35, 8'sd65, 20'd199680 - w, 15'd20480);
		end
		return r;
	endfunction

endpackage

@@ rtl/gsc_alu.sv @@
module gsc_alu (
	input  logic [103:0] a,
	input  logic [103:0] b,
	input  logic         sub,
	output logic [103:0] y,
	output logic         co
);
	// add, or subtract with carry out meaning a >= b
	assign {co, y} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {104'd0, sub};
endmodule

@@ rtl/gsc_core.sv @@
module gsc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  gsc_pkg::cfg_t    cfg,
	input  logic             start,
	input  gsc_pkg::item_t   item,
	output logic             idle,
	input  logic             res_ready,
	output logic             res_push,
	output gsc_pkg::result_t res
);
	import gsc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_DCHK = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_SQRT = 4'd4;
	localparam logic [3:0] ST_CSEL = 4'd5;
	localparam logic [3:0] ST_CNUM = 4'd6;
	localparam logic [3:0] ST_CSCL = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]   state_q;
	logic [5:0]   cnt_q;
	logic [1:0]   mop_q;
	logic         rmode_q;
	logic [1:0]   ch_q;
	logic [19:0]  wl_q;
	logic [1:0]   stat_q;
	logic [31:0]  ra_q, rb_q, am_q, bm_q;
	logic [103:0] acc_q, mcand_q, p_q;
	logic [31:0]  mplier_q;
	logic [63:0]  dv_q;
	logic [64:0]  rem_q;
	logic [39:0]  nsh_q, quo_q;
	logic [39:0]  sx_q, sres_q, sbit_q;
	logic [20:0]  num_q;
	logic [7:0]   red_q, green_q, blue_q;

	logic [32:0]  two_m;
	logic         horizon;
	logic [64:0]  div_t;
	logic [103:0] alu_a, alu_b, alu_y;
	logic         alu_sub, ge;
	ramp_t        sel;
	logic [39:0]  sres_nx;
	logic [39:0]  quo_nx;
	logic [21:0]  p0;
	logic signed [24:0] c1d, nsum;
	logic [20:0]  num_nx;
	logic [31:0]  numer;
	logic [21:0]  den2;
	logic         ch_wr;
	logic [7:0]   ch_val;

	assign two_m   = {cfg.mass, 1'b0};
	assign horizon = ({1'b0, item.radius_after} <= two_m) ||
		({1'b0, item.radius_before} <= two_m);
	assign div_t   = {rem_q[63:0], nsh_q[39]};
	assign sel     = ramp_info(wl_q, ch_q);
	assign quo_nx  = {quo_q[38:0], ge};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				alu_a = acc_q;
				alu_b = mplier_q[0] ? mcand_q : '0;
			end
			ST_DCHK: begin
				alu_a   = {40'd0, p_q[103:40]};
				alu_b   = {40'd0, dv_q};
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = {39'd0, div_t};
				alu_b   = {40'd0, dv_q};
				alu_sub = 1'b1;
			end
			ST_SQRT: begin
				alu_a   = {64'd0, sx_q};
				alu_b   = {64'd0, sres_q | sbit_q};
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
			end
		endcase
	end

	gsc_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y),
		.co  (ge)
	);

	assign sres_nx = ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);

	// ramp numerator, clamped at zero, then rounding scale to 0..255
	assign p0     = 22'(sel.c0) * 22'(sel.span);
	assign c1d    = 25'(sel.c1) * 25'($signed({1'b0, sel.d}));
	assign nsum   = $signed(25'(p0)) + c1d;
	assign num_nx = nsum[24] ? 21'd0 : nsum[20:0];
	assign numer  = 32'(num_q) * 32'd510 + 32'(sel.span) * 32'd100;
	assign den2   = 22'(sel.span) * 22'd200;

	always_comb begin
		ch_wr  = 1'b0;
		ch_val = sel.cval;
		if (state_q == ST_CSEL && !sel.is_ramp) begin
			ch_wr = 1'b1;
		end else if (state_q == ST_DIV && rmode_q && cnt_q == DIV_RAMP_LAST) begin
			ch_wr  = 1'b1;
			ch_val = quo_nx[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			mop_q   <= '0;
			rmode_q <= 1'b0;
			ch_q    <= CH_RED;
			wl_q    <= WL_RESET;
			stat_q  <= STAT_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ra_q <= item.radius_after;
						rb_q <= item.radius_before;
						am_q <= item.radius_after - two_m[31:0];
						bm_q <= item.radius_before - two_m[31:0];
						ch_q <= CH_RED;
						if (item.restart) begin
							wl_q    <= cfg.init_wl;
							stat_q  <= STAT_OK;
							state_q <= ST_CSEL;
						end else if (horizon) begin
							stat_q  <= STAT_HOR;
							state_q <= ST_CSEL;
						end else begin
							stat_q   <= STAT_OK;
							acc_q    <= '0;
							mcand_q  <= 104'(wl_q);
							mplier_q <= 32'(wl_q);
							mop_q    <= 2'd0;
							cnt_q    <= '0;
							state_q  <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					acc_q    <= alu_y;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) begin
						cnt_q <= '0;
						acc_q <= '0;
						mop_q <= mop_q + 2'd1;
						unique case (mop_q)
							2'd0: begin
								mcand_q  <= alu_y;
								mplier_q <= am_q;
							end
							2'd1: begin
								mcand_q  <= alu_y;
								mplier_q <= rb_q;
							end
							2'd2: begin
								p_q      <= alu_y;
								mcand_q  <= 104'(bm_q);
								mplier_q <= ra_q;
							end
							2'd3: begin
								dv_q    <= alu_y[63:0];
								state_q <= ST_DCHK;
							end
						endcase
					end
				end
				ST_DCHK: begin
					if (ge) begin
						// quotient reaches 2^40: root above the maximum
						wl_q    <= WL_MAX;
						stat_q  <= STAT_SAT;
						ch_q    <= CH_RED;
						state_q <= ST_CSEL;
					end else begin
						rem_q   <= {1'b0, p_q[103:40]};
						nsh_q   <= p_q[39:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						rmode_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? alu_y[64:0] : div_t;
					nsh_q <= nsh_q << 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 6'd1;
					if (!rmode_q && cnt_q == DIV_MAIN_LAST) begin
						sx_q    <= quo_nx;
						sres_q  <= '0;
						sbit_q  <= 40'h40_0000_0000;
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else if (rmode_q && cnt_q == DIV_RAMP_LAST) begin
						if (ch_q == CH_BLUE) state_q <= ST_DONE;
						else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_CSEL;
						end
					end
				end
				ST_SQRT: begin
					if (ge) sx_q <= alu_y[39:0];
					sres_q <= sres_nx;
					sbit_q <= sbit_q >> 2;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == SQRT_LAST) begin
						wl_q    <= sres_nx[19:0];
						ch_q    <= CH_RED;
						state_q <= ST_CSEL;
					end
				end
				ST_CSEL: begin
					if (sel.is_ramp) state_q <= ST_CNUM;
					else if (ch_q == CH_BLUE) state_q <= ST_DONE;
					else ch_q <= ch_q + 2'd1;
				end
				ST_CNUM: begin
					num_q   <= num_nx;
					state_q <= ST_CSCL;
				end
				ST_CSCL: begin
					rem_q   <= '0;
					nsh_q   <= {numer, 8'd0};
					dv_q    <= 64'(den2);
					quo_q   <= '0;
					cnt_q   <= '0;
					rmode_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ch_wr) begin
			unique case (ch_q)
				CH_RED:   red_q   <= ch_val;
				CH_GREEN: green_q <= ch_val;
				default:  blue_q  <= ch_val;
			endcase
		end
	end

	assign idle           = (state_q == ST_IDLE);
	assign res_push       = (state_q == ST_DONE) && res_ready;
	assign res.red        = red_q;
	assign res.green      = green_q;
	assign res.blue       = blue_q;
	assign res.wavelength = wl_q;
	assign res.status     = stat_q;

	a_restart_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && idle && item.restart |=> wl_q == $past(cfg.init_wl))
		else $error("restart did not load the initial wavelength");

	a_horizon_hold: assert property (@(posedge clk) disable iff (!arst_n)
		start && idle && !item.restart && horizon |=> wl_q == $past(wl_q) &&
		stat_q == STAT_HOR)
		else $error("horizon item changed the wavelength");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.status == STAT_SAT |-> res.wavelength == WL_MAX)
		else $error("saturated result below maximum");

	a_wl_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CSEL || state_q == ST_CNUM || state_q == ST_CSCL ||
		state_q == ST_DONE |=> $stable(wl_q) || $past(start))
		else $error("wavelength moved during color mapping");
endmodule

@@ rtl/gravitational_shift_color.sv @@
// Gravitational shift color: holds one photon wavelength (1/256 nm) and, for each
// request of radius_before and radius_after (unsigned Q16.16), scales it by
// sqrt((1 - 2M/radius_after) / (1 - 2M/radius_before)), truncated, then maps it to
// 8-bit RGB over 380..780 nm (black outside). Every request gives one result.
// A restart request reloads initial_wavelength with no shift; a radius at or inside
// 2M holds the wavelength with status 2; a result above the 20-bit maximum
// saturates with status 1. One shared 104-bit add/subtract unit does the products,
// divides and square root under a sequencer: four 32-step shift-add products, a
// 40-step restoring divide, a 20-step square root, and per ramped color channel a
// 32-step divide; a constant channel needs no divide. Input is taken only while
// the sequencer is idle; the finished result waits in an output register, and the
// next request may start while it waits.
module gravitational_shift_color (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // radius_before [31:0], radius_after [63:32]
	input  logic [0:0]  s_tuser,   // restart [0]
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // red [7:0], green [15:8], blue [23:16],
	                               // wavelength_now [43:24], zero [47:44]
	output logic [1:0]  m_tuser    // status [1:0]
);
	import gsc_pkg::*;

	logic [31:0] mass_q;
	logic [19:0] init_wl_q;
	logic        out_valid_q;
	result_t     out_q;

	cfg_t    cfg;
	item_t   item;
	result_t res;
	logic    idle, start, res_ready, res_push;

	// registers accept a write in every cycle; unknown indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q    <= MASS_RESET;
			init_wl_q <= WL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MASS) mass_q <= cfg_data;
			else if (cfg_index == REG_INIT_WL) init_wl_q <= cfg_data[19:0];
		end
	end

	assign cfg.mass    = mass_q;
	assign cfg.init_wl = init_wl_q;

	assign item.restart       = s_tuser[0];
	assign item.radius_before = s_tdata[31:0];
	assign item.radius_after  = s_tdata[63:32];

	assign s_tready = idle;
	assign start    = s_tvalid && s_tready;

	// hold the result until taken; refill in the cycle it leaves
	assign res_ready = !out_valid_q || m_tready;

	gsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.item      (item),
		.idle      (idle),
		.res_ready (res_ready),
		.res_push  (res_push),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.wavelength, out_q.blue, out_q.green, out_q.red};
	assign m_tuser  = out_q.status;
endmodule

@@ test/gravitational_shift_color_test.sv @@
module gravitational_shift_color_test;
	import gsc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // radius_before [31:0], radius_after [63:32]
	logic [0:0]  s_tuser;   // restart [0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // red, green, blue, wavelength_now, zero pad
	logic [1:0]  m_tuser;   // status

	localparam int CYCLE_LIMIT = 3000000;

	gravitational_shift_color dut (.*);

	// color of a wavelength: round(255 * (c0*span + c1*d) / (100*span))
	function automatic logic [7:0] ramp_value(longint c0, longint c1, longint d, longint span);
		longint num;
		longint den;
		num = c0 * span + c1 * d;
		den = 100 * span;
		if (num < 0) num = 0;
		return 8'((510 * num + den) / (2 * den));
	endfunction

	function automatic logic [23:0] wavelength_color(logic [19:0] w);
		longint x;
		logic [7:0] r, g, b;
		x = w;
		r = 0; g = 0; b = 0;
		if (x < 97280 || x > 199680) begin
		end else if (x <= 104960) begin
			r = ramp_value(60, -41, 104960 - x, 7680);
			b = ramp_value(39, 60, 104960 - x, 7680);
		end else if (x <= 112640) begin
			r = ramp_value(19, -19, 112640 - x, 7680);
			b = 255;
		end else if (x <= 125440) begin
			g = ramp_value(100, -100, 125440 - x, 12800);
			b = 255;
		end else if (x <= 130560) begin
			g = 255;
			b = ramp_value(0, 100, 130560 - x, 5120);
		end else if (x <= 148480) begin
			r = ramp_value(100, -100, 148480 - x, 17920);
			g = 255;
		end else if (x <= 163840) begin
			r = 255;
			g = ramp_value(0, 100, 163840 - x, 15360);
		end else if (x <= 179200) begin
			r = 255;
		end else begin
			r = ramp_value(35, 65, 199680 - x, 20480);
		end
		return {b, g, r};
	endfunction

	int mismatches = 0;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	class shift_scoreboard;
		logic [31:0] mass;
		logic [19:0] init_wl;
		logic [19:0] wavelength;
		result_t     pending[$];

		function new();
			mass       = MASS_RESET;
			init_wl    = WL_RESET;
			wavelength = WL_RESET;
		endfunction

		// predict the result of one accepted request
		function void note_request(logic restart, logic [31:0] rb, logic [31:0] ra);
			logic [32:0]  two_m;
			logic [127:0] num;
			logic [127:0] quo;
			logic [127:0] root;
			logic [1:0]   stat;
			result_t      res;
			two_m = {mass, 1'b0};
			stat  = STAT_OK;
			if (restart) begin
				wavelength = init_wl;
			end else if ({1'b0, ra} <= two_m || {1'b0, rb} <= two_m) begin
				stat = STAT_HOR;
			end else begin
				num = 128'(wavelength) * 128'(wavelength) * 128'(33'(ra) - two_m)
					* 128'(rb);
				quo = num / (128'(33'(rb) - two_m) * 128'(ra));
				if (quo >= 128'(64'd1) << 40) begin
					wavelength = WL_MAX;
					stat = STAT_SAT;
				end else begin
					root = 0;
					for (int i = 20; i >= 0; i--)
						if ((root | (128'd1 << i)) * (root | (128'd1 << i)) <= quo)
							root |= 128'd1 << i;
					if (root > 128'(WL_MAX)) begin
						wavelength = WL_MAX;
						stat = STAT_SAT;
					end else begin
						wavelength = root[19:0];
					end
				end
			end
			{res.blue, res.green, res.red} = wavelength_color(wavelength);
			res.wavelength = wavelength;
			res.status     = stat;
			pending.push_back(res);
		endfunction

		task check_result(logic [47:0] data, logic [1:0] stat);
			result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", data, 0);
				return;
			end
			want = pending.pop_front();
			if (data[7:0] != want.red) report_mismatch("red", data[7:0], want.red);
			if (data[15:8] != want.green) report_mismatch("green", data[15:8], want.green);
			if (data[23:16] != want.blue) report_mismatch("blue", data[23:16], want.blue);
			if (data[43:24] != want.wavelength)
				report_mismatch("wavelength", data[43:24], want.wavelength);
			if (data[47:44] != 0) report_mismatch("pad", data[47:44], 0);
			if (stat != want.status) report_mismatch("status", stat, want.status);
		endtask
	endclass

	shift_scoreboard board;
	bit  idle_on = 1;
	bit  hold_off = 0;
	longint cycles = 0;

	initial clk = 0;
	always #4 clk = ~clk;

	// monitor: sample all three handshakes at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (arst_n && s_tvalid && s_tready)
			board.note_request(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MASS) board.mass = cfg_data;
			else if (cfg_index == REG_INIT_WL) board.init_wl = cfg_data[19:0];
		end
	end

	// result side: random stall bursts, plus a long hold when asked
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) m_tready <= 0;
			else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				m_tready <= 1;
			end else m_tready <= 1;
		end
	end

	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// drop valid after each request, so valid is low before the next one starts
	task automatic send_request(logic restart, logic [31:0] rb, logic [31:0] ra);
		if (idle_on && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		else
			@(negedge clk);
		s_tvalid <= 1;
		s_tuser  <= restart;
		s_tdata  <= {ra, rb};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	// drain expectations, then let any work in flight settle
	task automatic wait_idle();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// radius outside 2M, mostly near the horizon so the shift is visible
	function automatic logic [31:0] outside_radius();
		logic [32:0] two_m;
		logic [32:0] r;
		two_m = {board.mass, 1'b0};
		case ($urandom_range(0, 4))
			0: r = two_m + 1 + $urandom_range(0, 255);
			1: r = two_m + 1 + ($urandom() & 32'h0003FFFF);
			2: r = two_m + 1 + ($urandom() & 32'h00FFFFFF);
			default: r = two_m + 1 + $urandom();
		endcase
		if (r > 33'hFFFFFFFF) r = 33'hFFFFFFFF;
		return r[31:0];
	endfunction

	task automatic random_phase(int count);
		logic [31:0] a, b;
		for (int i = 0; i < count; i++) begin
			a = outside_radius();
			b = outside_radius();
			case ($urandom_range(0, 19))
				0: send_request(1, $urandom(), $urandom());
				1: send_request(0, $urandom(), $urandom());
				2: send_request(0, $urandom_range(0, 3), b);
				default: send_request(0, a, b);
			endcase
		end
	endtask

	initial begin
		board = new();
		arst_n = 0;
		cfg_valid = 0; cfg_index = REG_MASS; cfg_data = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// directed: restart, horizon, zero radius, extremes, saturation
		send_request(1, 32'hFFFFFFFF, 0);
		send_request(0, 0, 0);
		send_request(0, 32'h00020000, 32'h00030000);
		send_request(0, 32'h00030000, 32'h00020000);
		send_request(0, 32'h00020001, 32'hFFFFFFFF);
		send_request(0, 32'hFFFFFFFF, 32'h00020001);
		send_request(0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(0, 32'h00028000, 32'h00100000);
		send_request(1, 0, 32'hFFFFFFFF);
		wait_idle();

		// walk color ramp boundaries with zero mass: shift is identity
		write_register(REG_MASS, 0);
		begin
			int wl[13] = '{97279, 97280, 104960, 104961, 112640, 125440, 130560,
				148480, 163840, 179200, 199680, 199681, 1048575};
			foreach (wl[k]) begin
				wait_idle();
				write_register(REG_INIT_WL, wl[k]);
				send_request(1, 32'h00010000, 32'h00010000);
				send_request(0, 32'h00010000, 32'h00010000);
			end
		end
		wait_idle();

		// pressure: hold results while requests keep coming
		write_register(REG_MASS, MASS_RESET);
		write_register(REG_INIT_WL, WL_RESET);
		fork
			begin
				hold_off = 1;
				repeat (2000) @(negedge clk);
				hold_off = 0;
			end
			random_phase(20);
		join
		wait_idle();

		// random phases across several settings, extremes included
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: write_register(REG_MASS, 32'hFFFFFFFF);
				1: write_register(REG_MASS, $urandom_range(1, 32'h00100000));
				2: write_register(REG_MASS, $urandom());
				default: write_register(REG_MASS, $urandom() & 32'h00FFFFFF);
			endcase
			case (p % 3)
				0: write_register(REG_INIT_WL, 20'hFFFFF);
				1: write_register(REG_INIT_WL, 0);
				default: write_register(REG_INIT_WL, $urandom_range(97280, 199680));
			endcase
			send_request(1, 0, 0);
			if (p == 6) idle_on = 0;
			random_phase(185);
			wait_idle();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/gsc_pkg.sv
rtl/gsc_alu.sv
rtl/gsc_core.sv
rtl/gravitational_shift_color.sv
test/gravitational_shift_color_test.sv
